### rtl/core/ipb_pkg.sv
`default_nettype none

package ipb_pkg;

   // payload bytes carried by one beat (bytes 0..3 in lo, byte 4 in hi)
   localparam int DATA_BYTES = 5;
   localparam int DATA_BITS  = 8 * DATA_BYTES;

   typedef enum logic [2:0] {
      REQ_NOTIFY  = 3'd0,
      REQ_CONFIRM = 3'd1,
      REQ_TICK    = 3'd2,
      REQ_OPEN    = 3'd3,
      REQ_CLOSE   = 3'd4,
      REQ_ENABLE  = 3'd5,
      REQ_BONDED  = 3'd6
   } ipb_req_code_type;

   localparam logic CHAN_TEMP   = 1'b0;
   localparam logic CHAN_BUTTON = 1'b1;

   typedef struct packed {
      ipb_req_code_type req_type;
      logic             channel;
      logic [15:0]      char_handle;
      logic [2:0]       payload_len;
      logic [31:0]      payload_lo;
      logic [7:0]       payload_hi;
      logic             enable_value;
   } ipb_req_type;

   typedef struct packed {
      logic        send_valid;
      logic [15:0] send_handle;
      logic [2:0]  send_len;
      logic [31:0] send_lo;
      logic [7:0]  send_hi;
      logic        queued;
      logic        dropped;
      logic [4:0]  backlog_count;
   } ipb_rsp_type;

   // one backlog entry, payload already trimmed to its length
   typedef struct packed {
      logic [15:0]          handle;
      logic [2:0]           len;
      logic [DATA_BITS-1:0] data;
   } ipb_entry_type;

   // core to backlog storage
   typedef struct packed {
      logic push;
      logic pop;
   } ipb_fifo_cmd_type;

endpackage

`default_nettype wire

### rtl/core/ipb_backlog_ram.sv
`default_nettype none

module ipb_backlog_ram
   import ipb_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ipb_fifo_cmd_type cmd,
   input  wire ipb_entry_type    wr_entry,
   output      ipb_entry_type    head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   ipb_entry_type mem [DEPTH];

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   ipb_entry_type head_ff;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = cmd.push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = cmd.pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // head register always holds the entry at the next read pointer
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ptr_ff] <= wr_entry;
      end
      if (cmd.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wr_entry;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign head = head_ff;

endmodule

`default_nettype wire

### rtl/core/ipb_pacer_core.sv
`default_nettype none

module ipb_pacer_core
   import ipb_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire ipb_req_type      item,
   input  wire ipb_entry_type    head,
   output      ipb_fifo_cmd_type cmd,
   output      ipb_entry_type    wr_entry,
   output      ipb_rsp_type      rsp
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [2:0] LEN_MAX = 3'(DATA_BYTES);

   logic conn_open_ff, conn_open_in;
   logic in_flight_ff, in_flight_in;
   logic temp_en_ff, temp_en_in;
   logic button_en_ff, button_en_in;
   logic bonded_ff, bonded_in;
   logic full_ff, full_in;
   logic [CW-1:0] count_ff, count_in;

   logic [2:0] len_sat;
   logic [DATA_BITS-1:0] data_raw;
   logic [DATA_BITS-1:0] data_trim;
   logic allowed;
   logic [CW+4:0] count_ext;

   always_comb begin
      len_sat  = (item.payload_len > LEN_MAX) ? LEN_MAX : item.payload_len;
      data_raw = {item.payload_hi, item.payload_lo};
      for (int b = 0; b < DATA_BYTES; b++) begin
         data_trim[8*b +: 8] = (3'(b) < len_sat) ? data_raw[8*b +: 8] : 8'h00;
      end
      allowed = conn_open_ff &&
                ((item.channel == CHAN_BUTTON) ? (button_en_ff && bonded_ff) : temp_en_ff);
      wr_entry.handle = item.char_handle;
      wr_entry.len    = len_sat;
      wr_entry.data   = data_trim;
   end

   always_comb begin
      conn_open_in = conn_open_ff;
      in_flight_in = in_flight_ff;
      temp_en_in   = temp_en_ff;
      button_en_in = button_en_ff;
      bonded_in    = bonded_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      cmd          = '0;
      rsp          = '0;
      if (go) begin
         unique case (item.req_type)
            REQ_NOTIFY: begin
               if (allowed) begin
                  if (!in_flight_ff) begin
                     rsp.send_valid  = 1'b1;
                     rsp.send_handle = item.char_handle;
                     rsp.send_len    = len_sat;
                     rsp.send_lo     = data_trim[31:0];
                     rsp.send_hi     = data_trim[39:32];
                     in_flight_in    = 1'b1;
                  end else if (full_ff || (count_ff >= FULL_COUNT)) begin
                     rsp.dropped = 1'b1;
                  end else begin
                     cmd.push   = 1'b1;
                     count_in   = count_ff + 1'b1;
                     full_in    = (count_in >= FULL_COUNT);
                     rsp.queued = 1'b1;
                  end
               end
            end
            REQ_CONFIRM: in_flight_in = 1'b0;
            REQ_TICK: begin
               if ((count_ff != '0) && !in_flight_ff && (button_en_ff || temp_en_ff)) begin
                  cmd.pop         = 1'b1;
                  rsp.send_valid  = 1'b1;
                  rsp.send_handle = head.handle;
                  rsp.send_len    = head.len;
                  rsp.send_lo     = head.data[31:0];
                  rsp.send_hi     = head.data[39:32];
                  in_flight_in    = 1'b1;
                  count_in        = count_ff - 1'b1;
                  full_in         = 1'b0;
               end
            end
            REQ_OPEN: begin
               conn_open_in = 1'b1;
               in_flight_in = 1'b0;
            end
            REQ_CLOSE: begin
               conn_open_in = 1'b0;
               in_flight_in = 1'b0;
            end
            REQ_ENABLE: begin
               if (item.channel == CHAN_BUTTON) begin
                  button_en_in = item.enable_value;
               end else begin
                  temp_en_in = item.enable_value;
               end
            end
            REQ_BONDED: bonded_in = 1'b1;
            default: ;
         endcase
      end
      count_ext         = {5'b0, count_in};
      rsp.backlog_count = count_ext[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_open_ff <= 1'b0;
         in_flight_ff <= 1'b0;
         temp_en_ff   <= 1'b0;
         button_en_ff <= 1'b0;
         bonded_ff    <= 1'b0;
         full_ff      <= 1'b0;
         count_ff     <= '0;
      end else begin
         conn_open_ff <= conn_open_in;
         in_flight_ff <= in_flight_in;
         temp_en_ff   <= temp_en_in;
         button_en_ff <= button_en_in;
         bonded_ff    <= bonded_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT) else $error("backlog count beyond depth");

   a_full_tracks_count: assert property (@(posedge clock) disable iff (reset)
      full_ff == (count_ff == FULL_COUNT)) else $error("full flag out of step with count");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (count_ff == $past(count_ff) + 1'b1) && in_flight_ff)
      else $error("push did not bump count");

   a_send_sets_flight: assert property (@(posedge clock) disable iff (reset)
      rsp.send_valid |=> in_flight_ff) else $error("send left in-flight clear");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      $onehot0({rsp.send_valid, rsp.queued, rsp.dropped}))
      else $error("more than one outcome for a beat");

endmodule

`default_nettype wire

### rtl/core/indication_pacer_with_backlog.sv
`default_nettype none

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------
// req_     | in        | req_valid / req_ready  | req_data  (ipb_req_type)
// rsp_     | out       | rsp_valid / rsp_ready  | rsp_data  (ipb_rsp_type)
//
// every input beat yields exactly one response beat, via the input then the response register
// one beat per cycle unless rsp_ready stalls; one backlog write or read per beat, plus flags
// backlog head is prefetched into a register, so a tick takes it from that register
// synchronous active-high reset clears flags, pointers and count; entries are not cleared
// a stalled rsp_ready holds the response register and the input register behind it

module indication_pacer_with_backlog
   import ipb_pkg::*;
#(
   parameter int BACKLOG_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire ipb_req_type req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      ipb_rsp_type rsp_data
);

   // input register stage
   logic        in_vld_ff;
   ipb_req_type in_ff;

   // response register stage
   logic        out_vld_ff;
   ipb_rsp_type out_ff;

   logic advance;
   logic go;

   ipb_fifo_cmd_type fifo_cmd;
   ipb_entry_type    fifo_wr;
   ipb_entry_type    fifo_head;
   ipb_rsp_type      rsp_next;

   // response slot is free or being drained this cycle
   assign advance   = !out_vld_ff || rsp_ready;
   // beat in the input register gets processed this cycle
   assign go        = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         out_ff <= rsp_next;
      end
   end

   ipb_pacer_core #(
      .DEPTH (BACKLOG_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .item     (in_ff),
      .head     (fifo_head),
      .cmd      (fifo_cmd),
      .wr_entry (fifo_wr),
      .rsp      (rsp_next)
   );

   ipb_backlog_ram #(
      .DEPTH (BACKLOG_DEPTH)
   ) u_backlog (
      .clock    (clock),
      .reset    (reset),
      .cmd      (fifo_cmd),
      .wr_entry (fifo_wr),
      .head     (fifo_head)
   );

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
